// ===== hw/rtl/gbr_pkg.sv =====
package gbr_pkg;

  localparam int SCREEN_WIDTH = 640;
  localparam int LINE_GAP     = 10;
  localparam int X_LIMIT      = (SCREEN_WIDTH < 1024) ? SCREEN_WIDTH : 1024;

  localparam int ROW_W       = 48;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 12;

  localparam logic [7:0]  CODE_LO    = 8'hA1;
  localparam logic [7:0]  CODE_HI    = 8'hFE;
  localparam logic [13:0] AREA_COUNT = 14'd94;

  localparam logic [5:0] SIZE_PX0 = 6'd16;
  localparam logic [5:0] SIZE_PX1 = 6'd24;
  localparam logic [5:0] SIZE_PX2 = 6'd32;
  localparam logic [5:0] SIZE_PX3 = 6'd48;

  localparam logic [1:0] KIND_BEGIN = 2'd0;
  localparam logic [1:0] KIND_CHAR  = 2'd1;
  localparam logic [1:0] KIND_ROW   = 2'd2;

  localparam logic OUT_ADDR  = 1'b0;
  localparam logic OUT_PIXEL = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] CFG_GLYPH_SIZE   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_START_X      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_START_Y      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_CHAR_ADVANCE = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_COLOR        = 3'd4;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       code_first;
    logic [7:0]       code_second;
    logic [ROW_W-1:0] row_bits;
  } req_t;

  typedef struct packed {
    logic        out_kind;
    logic [21:0] font_address;
    logic        bad_code;
    logic [9:0]  pixel_x;
    logic [11:0] pixel_y;
    logic [3:0]  pixel_color;
    logic        last;
  } rsp_t;

  typedef struct packed {
    logic [1:0]  glyph_size;
    logic [9:0]  start_x;
    logic [11:0] start_y;
    logic [9:0]  char_advance;
    logic [3:0]  color;
  } cfg_t;

  typedef struct packed {
    logic begin_text;
    logic char_load;
    logic row_load;
    logic emit_addr;
    logic scan_step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic glyph_open;
    logic scan_empty;
    logic scan_last;
  } dp_status_t;

  function automatic logic [5:0] glyph_px(input logic [1:0] sel);
    logic [5:0] px;
    unique case (sel)
      2'd0:    px = SIZE_PX0;
      2'd1:    px = SIZE_PX1;
      2'd2:    px = SIZE_PX2;
      default: px = SIZE_PX3;
    endcase
    return px;
  endfunction

  function automatic logic [8:0] glyph_bytes(input logic [1:0] sel);
    logic [8:0] nb;
    unique case (sel)
      2'd0:    nb = 9'd32;
      2'd1:    nb = 9'd72;
      2'd2:    nb = 9'd128;
      default: nb = 9'd288;
    endcase
    return nb;
  endfunction

endpackage

// ===== hw/rtl/gbr_cfg.sv =====
module gbr_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [gbr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [gbr_pkg::CFG_DATA_W-1:0]  cfg_data,
  output gbr_pkg::cfg_t                  cfg
);
  import gbr_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.glyph_size   <= 2'd0;
      cfg.start_x      <= 10'd0;
      cfg.start_y      <= 12'd0;
      cfg.char_advance <= 10'd16;
      cfg.color        <= 4'd15;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_GLYPH_SIZE:   cfg.glyph_size   <= cfg_data[1:0];
        CFG_START_X:      cfg.start_x      <= cfg_data[9:0];
        CFG_START_Y:      cfg.start_y      <= cfg_data[11:0];
        CFG_CHAR_ADVANCE: cfg.char_advance <= cfg_data[9:0];
        CFG_COLOR:        cfg.color        <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/gbr_ctrl.sv =====
module gbr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  logic [1:0]          kind,
  input  gbr_pkg::dp_status_t status,
  output gbr_pkg::ctrl_cmd_t  cmd
);
  import gbr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_ADDR = 3'b010,
    ST_SCAN = 3'b100
  } state_t;

  state_t state, state_next;

  assign req_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          unique case (kind)
            KIND_BEGIN: cmd.begin_text = 1'b1;
            KIND_CHAR: begin
              cmd.char_load = 1'b1;
              state_next    = ST_ADDR;
            end
            KIND_ROW: begin
              if (status.glyph_open) begin
                cmd.row_load = 1'b1;
                state_next   = ST_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      ST_ADDR: begin
        if (status.out_free) begin
          cmd.emit_addr = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (status.scan_empty) begin
          state_next = ST_IDLE;
        end else if (status.out_free) begin
          cmd.scan_step = 1'b1;
          if (status.scan_last) state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  a_addr_one_shot: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ADDR && status.out_free) |=> (state == ST_IDLE))
    else $error("address request did not return to idle");

endmodule

// ===== hw/rtl/gbr_dp.sv =====
module gbr_dp (
  input  logic                clk,
  input  logic                rst,
  input  gbr_pkg::cfg_t       cfg,
  input  gbr_pkg::req_t       req,
  input  gbr_pkg::ctrl_cmd_t  cmd,
  output gbr_pkg::dp_status_t status,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output gbr_pkg::rsp_t       rsp
);
  import gbr_pkg::*;

  logic [9:0]       cursor_x;
  logic [11:0]      line_top;
  logic [5:0]       row_count;
  logic             glyph_open;
  logic             char_bad;
  logic [1:0]       char_size;
  logic [13:0]      glyph_index;
  logic [ROW_W-1:0] scan_mask;
  logic [9:0]       scan_x;
  logic [11:0]      scan_y;
  logic [5:0]       scan_j;

  logic [5:0]       size_px;
  logic [7:0]       area_off, pos_off;
  logic             codes_ok;
  logic [13:0]      index_next;
  logic             wrap;
  logic [12:0]      line_down;
  logic [11:0]      line_down_sat;
  logic [12:0]      row_y;
  logic [5:0]       row_count_next;
  logic             glyph_done;
  logic [10:0]      adv_sum;
  logic [9:0]       cursor_adv;
  logic [10:0]      avail;
  logic [ROW_W-1:0] row_rev;
  logic [ROW_W-1:0] mask_next;
  logic [22:0]      addr_prod;
  rsp_t             addr_rsp, pix_rsp;

  assign size_px  = glyph_px(cfg.glyph_size);
  assign area_off = req.code_first - CODE_LO;
  assign pos_off  = req.code_second - CODE_LO;
  assign codes_ok = (req.code_first >= CODE_LO) && (req.code_first <= CODE_HI) &&
                    (req.code_second >= CODE_LO) && (req.code_second <= CODE_HI);
  assign index_next = 14'(AREA_COUNT * 14'(area_off[6:0])) + 14'(pos_off[6:0]);

  assign wrap          = 11'(cursor_x) >= (11'(SCREEN_WIDTH) - 11'(size_px));
  assign line_down     = 13'(line_top) + 13'(size_px) + 13'(LINE_GAP);
  assign line_down_sat = line_down[12] ? 12'hFFF : line_down[11:0];

  assign row_y          = 13'(line_top) + 13'(row_count);
  assign row_count_next = row_count + 6'd1;
  assign glyph_done     = (row_count_next >= size_px) || (row_count_next == 6'd0);
  assign adv_sum        = 11'(cursor_x) + 11'(cfg.char_advance);
  assign cursor_adv     = adv_sum[10] ? 10'h3FF : adv_sum[9:0];
  assign avail = (11'(cursor_x) >= 11'(X_LIMIT)) ? 11'd0 : 11'(X_LIMIT) - 11'(cursor_x);

  // leftmost pixel of the row lands at bit 0
  always_comb begin
    row_rev = '0;
    unique case (cfg.glyph_size)
      2'd0: for (int j = 0; j < int'(SIZE_PX0); j++)
              row_rev[j] = req.row_bits[int'(SIZE_PX0) - 1 - j];
      2'd1: for (int j = 0; j < int'(SIZE_PX1); j++)
              row_rev[j] = req.row_bits[int'(SIZE_PX1) - 1 - j];
      2'd2: for (int j = 0; j < int'(SIZE_PX2); j++)
              row_rev[j] = req.row_bits[int'(SIZE_PX2) - 1 - j];
      default: for (int j = 0; j < int'(SIZE_PX3); j++)
              row_rev[j] = req.row_bits[int'(SIZE_PX3) - 1 - j];
    endcase
  end

  always_comb begin
    for (int j = 0; j < ROW_W; j++) begin
      mask_next[j] = row_rev[j] && (11'(j) < avail) && !row_y[12];
    end
  end

  assign addr_prod = 23'(glyph_index) * 23'(glyph_bytes(char_size));

  always_comb begin
    addr_rsp              = '0;
    addr_rsp.out_kind     = OUT_ADDR;
    addr_rsp.bad_code     = char_bad;
    addr_rsp.font_address = char_bad ? 22'd0 : addr_prod[21:0];
    addr_rsp.last         = 1'b1;
  end

  always_comb begin
    pix_rsp             = '0;
    pix_rsp.out_kind    = OUT_PIXEL;
    pix_rsp.pixel_x     = scan_x + 10'(scan_j);
    pix_rsp.pixel_y     = scan_y;
    pix_rsp.pixel_color = cfg.color;
    pix_rsp.last        = status.scan_last;
  end

  assign status.out_free   = !rsp_valid || !rsp_stall;
  assign status.glyph_open = glyph_open;
  assign status.scan_empty = (scan_mask == '0);
  assign status.scan_last  = (scan_mask[ROW_W-1:1] == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x   <= '0;
      line_top   <= '0;
      row_count  <= '0;
      glyph_open <= 1'b0;
      scan_mask  <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (cmd.begin_text) begin
        cursor_x   <= cfg.start_x;
        line_top   <= cfg.start_y;
        row_count  <= '0;
        glyph_open <= 1'b0;
      end
      if (cmd.char_load) begin
        row_count  <= '0;
        glyph_open <= codes_ok;
        if (codes_ok && wrap) begin
          cursor_x <= cfg.start_x;
          line_top <= line_down_sat;
        end
      end
      if (cmd.row_load) begin
        scan_mask <= mask_next;
        if (glyph_done) begin
          cursor_x   <= cursor_adv;
          row_count  <= '0;
          glyph_open <= 1'b0;
        end else begin
          row_count <= row_count_next;
        end
      end
      if (cmd.scan_step) scan_mask <= scan_mask >> 1;
      if (cmd.emit_addr || (cmd.scan_step && scan_mask[0])) rsp_valid <= 1'b1;
      else if (!rsp_stall)                                   rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.char_load) begin
      char_bad    <= !codes_ok;
      char_size   <= cfg.glyph_size;
      glyph_index <= index_next;
    end
    if (cmd.row_load) begin
      scan_x <= cursor_x;
      scan_y <= row_y[11:0];
      scan_j <= '0;
    end
    if (cmd.scan_step) scan_j <= scan_j + 6'd1;
    if (cmd.emit_addr)                     rsp <= addr_rsp;
    else if (cmd.scan_step && scan_mask[0]) rsp <= pix_rsp;
  end

  a_bad_no_addr: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.bad_code) |-> (rsp.font_address == 22'd0))
    else $error("bad code request carries an address");

  a_pixel_on_screen: assert property (@(posedge clk) disable iff (rst)
    (cmd.scan_step && scan_mask[0]) |=> (11'(rsp.pixel_x) < 11'(X_LIMIT)))
    else $error("pixel write off screen");

  a_row_needs_glyph: assert property (@(posedge clk) disable iff (rst)
    cmd.row_load |-> glyph_open)
    else $error("row loaded with no open glyph");

endmodule

// ===== hw/rtl/gb2312_glyph_rasterizer.sv =====
// Begin item: taken while idle, no result. Character item: one address request once the
// output is free. Glyph row: a load, then one column per cycle while the output is free,
// up to the last on-screen set pixel (at most 48), one pixel write per set pixel.
// Throughput is set by the single-column scan shift register feeding the output register.
// rst (synchronous, active high) clears cursor, line and glyph state and loads the
// register defaults: size 16, start 0,0, advance 16, color 15.
module gb2312_glyph_rasterizer (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_stall,
  input  gbr_pkg::req_t                   req,
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output gbr_pkg::rsp_t                   rsp,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [gbr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [gbr_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import gbr_pkg::*;

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t status;

  gbr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  gbr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .kind      (req.kind),
    .status    (status),
    .cmd       (cmd)
  );

  gbr_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req       (req),
    .cmd       (cmd),
    .status    (status),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
  import gbr_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE      = 120;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  logic clk;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  gb2312_glyph_rasterizer DUT (.*);

  // shadow of the block's registers and text state
  logic [1:0] m_size;
  int m_start_x, m_start_y, m_advance;
  logic [3:0] m_color;
  int cur_x, line_y, rows_done;
  bit glyph_on;

  rsp_t raster_out_q[$];
  rsp_t want;
  int send_idle, recv_stall;
  logic hold_on = 1'b0;
  int mism = 0;
  int cycles = 0;
  int offered = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int px_of(input logic [1:0] s);
    case (s)
      2'd0: return 16;
      2'd1: return 24;
      2'd2: return 32;
      default: return 48;
    endcase
  endfunction

  function automatic int bytes_of(input logic [1:0] s);
    case (s)
      2'd0: return 32;
      2'd1: return 72;
      2'd2: return 128;
      default: return 288;
    endcase
  endfunction

  function automatic req_t mk_item(input logic [1:0] k, input logic [7:0] a, p,
                                   input logic [47:0] bits);
    req_t r;
    r.kind = k;
    r.code_first = a;
    r.code_second = p;
    r.row_bits = bits;
    return r;
  endfunction

  function automatic string show(input rsp_t v);
    return $sformatf("kind=%0d addr=%0d bad=%0d x=%0d y=%0d color=%0d last=%0d",
                     v.out_kind, v.font_address, v.bad_code, v.pixel_x, v.pixel_y,
                     v.pixel_color, v.last);
  endfunction

  function automatic void rasterize_item(input req_t r);
    int sz, a, p, py, px, ny;
    int xs[$];
    rsp_t e;
    sz = px_of(m_size);
    e = '0;
    case (r.kind)
      KIND_BEGIN: begin
        cur_x = m_start_x;
        line_y = m_start_y;
        rows_done = 0;
        glyph_on = 0;
      end
      KIND_CHAR: begin
        glyph_on = 0;
        rows_done = 0;
        e.out_kind = OUT_ADDR;
        e.last = 1'b1;
        if (r.code_first < CODE_LO || r.code_first > CODE_HI ||
            r.code_second < CODE_LO || r.code_second > CODE_HI) begin
          e.bad_code = 1'b1;
        end else begin
          if (cur_x >= SCREEN_WIDTH - sz) begin
            ny = line_y + sz + LINE_GAP;
            cur_x = m_start_x;
            line_y = (ny > 4095) ? 4095 : ny;
          end
          a = r.code_first - CODE_LO;
          p = r.code_second - CODE_LO;
          e.font_address = 22'((94 * a + p) * bytes_of(m_size));
          glyph_on = 1;
        end
        raster_out_q.push_back(e);
      end
      KIND_ROW: begin
        if (glyph_on) begin
          py = line_y + rows_done;
          if (py <= 4095) begin
            for (int j = 0; j < sz; j++) begin
              px = cur_x + j;
              if (r.row_bits[sz-1-j] && px < SCREEN_WIDTH && px <= 1023) xs.push_back(px);
            end
          end
          for (int k = 0; k < xs.size(); k++) begin
            e.out_kind = OUT_PIXEL;
            e.pixel_x = 10'(xs[k]);
            e.pixel_y = 12'(py);
            e.pixel_color = m_color;
            e.last = (k == xs.size() - 1);
            raster_out_q.push_back(e);
          end
          rows_done = (rows_done + 1) & 63;
          if (rows_done >= sz || rows_done == 0) begin
            cur_x = (cur_x + m_advance > 1023) ? 1023 : cur_x + m_advance;
            rows_done = 0;
            glyph_on = 0;
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic offer_item(input req_t r);
    while ($urandom_range(0, 99) < send_idle) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    rasterize_item(r);
    offered++;
  endtask

  task automatic settle();
    req_valid <= 1'b0;
    while (raster_out_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_INDEX_W-1:0] idx, input int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(val);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_GLYPH_SIZE:   m_size = 2'(val);
      CFG_START_X:      m_start_x = val & 'h3FF;
      CFG_START_Y:      m_start_y = val & 'hFFF;
      CFG_CHAR_ADVANCE: m_advance = val & 'h3FF;
      CFG_COLOR:        m_color = 4'(val);
      default: ;
    endcase
  endtask

  task automatic write_regs(input int sz, sx, sy, adv, col);
    put_reg(CFG_GLYPH_SIZE, sz);
    put_reg(CFG_START_X, sx);
    put_reg(CFG_START_Y, sy);
    put_reg(CFG_CHAR_ADVANCE, adv);
    put_reg(CFG_COLOR, col);
    cfg_valid <= 1'b0;
  endtask

  task automatic hold_receiver(input int n);
    hold_on <= 1'b1;
    repeat (n) @(posedge clk);
    hold_on <= 1'b0;
  endtask

  function automatic logic [47:0] random_row();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    case ($urandom_range(0, 5))
      0: return 48'hFFFF_FFFF_FFFF;
      1: return 48'h0;
      2: return 48'h1 << $urandom_range(0, 47);
      default: return w[47:0];
    endcase
  endfunction

  function automatic int pick_extreme(input int hi);
    case ($urandom_range(0, 5))
      0: return 0;
      1: return hi;
      default: return $urandom_range(0, hi);
    endcase
  endfunction

  task automatic test_codes();
    offer_item(mk_item(KIND_BEGIN, 8'h00, 8'h00, 48'h0));
    offer_item(mk_item(KIND_CHAR, CODE_LO, CODE_LO, 48'h0));
    offer_item(mk_item(KIND_ROW, 8'h00, 8'h00, 48'hFFFF_FFFF_FFFF));
    offer_item(mk_item(KIND_ROW, 8'h00, 8'h00, 48'h0));
    offer_item(mk_item(KIND_ROW, 8'h00, 8'h00, 48'h8000_0000_8001));
    offer_item(mk_item(KIND_UNUSED, 8'hFF, 8'hFF, 48'hFFFF_FFFF_FFFF));
    // new character abandons the open one
    offer_item(mk_item(KIND_CHAR, CODE_HI, CODE_HI, 48'h0));
    offer_item(mk_item(KIND_ROW, 8'h00, 8'h00, 48'h5555_AAAA_A5A5));
    offer_item(mk_item(KIND_CHAR, 8'hA0, CODE_LO, 48'h0));
    offer_item(mk_item(KIND_ROW, 8'h00, 8'h00, 48'hFFFF_FFFF_FFFF));
    offer_item(mk_item(KIND_CHAR, CODE_LO, 8'hFF, 48'h0));
    offer_item(mk_item(KIND_CHAR, 8'h00, 8'h00, 48'h0));
    offer_item(mk_item(KIND_CHAR, 8'hFF, 8'hA0, 48'h0));
    settle();
  endtask

  task automatic test_edges();
    // start column past the wrap point, line top saturating at the bottom
    write_regs(3, 639, 4090, 639, 0);
    offer_item(mk_item(KIND_BEGIN, 8'h00, 8'h00, 48'h0));
    offer_item(mk_item(KIND_CHAR, CODE_HI, CODE_HI, 48'h0));
    offer_item(mk_item(KIND_ROW, 8'h00, 8'h00, 48'hFFFF_FFFF_FFFF));
    offer_item(mk_item(KIND_ROW, 8'h00, 8'h00, 48'hFFFF_FFFF_FFFF));
    settle();
  endtask

  task automatic test_backpressure();
    write_regs(0, 100, 20, 16, 9);
    send_idle = 0;
    recv_stall = 0;
    fork
      hold_receiver(400);
    join_none
    offer_item(mk_item(KIND_BEGIN, 8'h00, 8'h00, 48'h0));
    offer_item(mk_item(KIND_CHAR, 8'hB0, 8'hC5, 48'h0));
    repeat (16) offer_item(mk_item(KIND_ROW, 8'h00, 8'h00, 48'hFFFF_FFFF_FFFF));
    settle();
  endtask

  task automatic test_random();
    int idle_pat[4];
    int stall_pat[4];
    int base, c, sz, nrows, sel;
    idle_pat = '{0, 70, 0, 18};
    stall_pat = '{0, 0, 70, 18};
    for (int ph = 0; ph < 4; ph++) begin
      sel = $urandom_range(0, 9);
      write_regs((sel < 6) ? 0 : (sel < 8) ? 1 : (sel < 9) ? 2 : 3,
                 pick_extreme(639),
                 ($urandom_range(0, 3) == 0) ? pick_extreme(4095) : $urandom_range(0, 600),
                 pick_extreme(639), $urandom_range(0, 15));
      send_idle = idle_pat[ph];
      recv_stall = stall_pat[ph];
      // glyph left open from the previous phase continues under the new size
      if ($urandom_range(0, 1)) offer_item(mk_item(KIND_BEGIN, 8'h00, 8'h00, 48'h0));
      base = offered;
      while (offered - base < 10) begin
        c = $urandom_range(0, 99);
        sz = px_of(m_size);
        if (c < 8) begin
          offer_item(mk_item(KIND_BEGIN, 8'h00, 8'h00, random_row()));
        end else if (c < 16) begin
          offer_item(mk_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255)), random_row()));
        end else if (c < 24) begin
          offer_item(mk_item(KIND_CHAR, 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255)), random_row()));
        end else begin
          offer_item(mk_item(KIND_CHAR, 8'($urandom_range(CODE_LO, CODE_HI)),
                             8'($urandom_range(CODE_LO, CODE_HI)), 48'h0));
          nrows = ($urandom_range(0, 3) != 0) ? sz : $urandom_range(0, sz + 2);
          repeat (nrows) offer_item(mk_item(KIND_ROW, 8'h00, 8'h00, random_row()));
        end
      end
      settle();
    end
  endtask

  always @(posedge clk) begin
    rsp_stall <= hold_on || ($urandom_range(0, 99) < recv_stall);
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (raster_out_q.size() == 0) begin
        mism++;
        if (mism <= 10) $display("unexpected output: %s", show(rsp));
      end else begin
        want = raster_out_q.pop_front();
        if (rsp.out_kind !== want.out_kind || rsp.font_address !== want.font_address ||
            rsp.bad_code !== want.bad_code || rsp.pixel_x !== want.pixel_x ||
            rsp.pixel_y !== want.pixel_y || rsp.pixel_color !== want.pixel_color ||
            rsp.last !== want.last) begin
          mism++;
          if (mism <= 10) $display("mismatch: exp %s / got %s", show(want), show(rsp));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    send_idle = 0;
    recv_stall = 0;
    m_size = 2'd0;
    m_start_x = 0;
    m_start_y = 0;
    m_advance = 16;
    m_color = 4'd15;
    cur_x = 0;
    line_y = 0;
    rows_done = 0;
    glyph_on = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_codes();
    test_edges();
    test_backpressure();
    test_random();
    settle();
    if (mism == 0 && raster_out_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
